@@ sv/lli_pkg.sv @@
// Shared types and constants for the line-line intersection block.
// No dependencies.
`default_nettype none
package lli_pkg;

  localparam int THR_W = 51;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

endpackage
`default_nettype wire

@@ sv/lli_if.sv @@
// Handshake interfaces for the line pair, result and threshold channels.
// Depends on lli_pkg.
`default_nettype none
interface lli_in_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] a_start_x;
  logic [W-1:0] a_start_y;
  logic [W-1:0] a_end_x;
  logic [W-1:0] a_end_y;
  logic [W-1:0] b_start_x;
  logic [W-1:0] b_start_y;
  logic [W-1:0] b_end_x;
  logic [W-1:0] b_end_y;
  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface lli_out_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [1:0]   status;
  logic [W-1:0] cross_x;
  logic [W-1:0] cross_y;
  modport source (output valid, status, cross_x, cross_y, input ready);
  modport sink (input valid, status, cross_x, cross_y, output ready);
endinterface

interface lli_cfg_if;
  import lli_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ sv/lli_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// No dependencies.
`default_nettype none
module lli_div #(
  parameter int W = 24
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [3*W:0] num_i,
  input  wire logic [2*W:0] den_i,
  output logic [W:0]   quo_o,
  output logic         ovf_o
);
  localparam int DW = 2 * W + 1;
  localparam int NW = 3 * W + 1;
  localparam int QB = W + 1;

  logic [DW-1:0] rem_q [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic [QB-1:0] low_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic          ovf_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {1'b0, num_i[NW-1:QB]};
      ovf_q[0] <= {1'b0, num_i[NW-1:QB]} >= den_i;
      low_q[0] <= num_i[QB-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [DW:0] t;
    logic        ge;
    logic [DW:0] diff;
    always_comb begin
      t    = {rem_q[i-1], low_q[i-1][QB-1]};
      ge   = t >= {1'b0, den_q[i-1]};
      diff = t - {1'b0, den_q[i-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
        low_q[i] <= {low_q[i-1][QB-2:0], 1'b0};
        quo_q[i] <= {quo_q[i-1][QB-2:0], ge};
        den_q[i] <= den_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  assign quo_o = quo_q[QB];
  assign ovf_o = ovf_q[QB];
endmodule
`default_nettype wire

@@ sv/line_line_intersection_top.sv @@
// A line pair passes through the stage registers, the divider and the output register.
// Throughput: one line pair per cycle; the whole pipeline advances together
// and holds while the output register is full and not taken.
// The quotient comes from a restoring divider that resolves one bit per stage.
// Reset clears the valid bits and sets the threshold to 1.
// Depends on lli_pkg, lli_if and lli_div.
`default_nettype none
module line_line_intersection_top
  import lli_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lli_cfg_if.sink cfg_i,
  lli_in_if.sink  pt_i,
  lli_out_if.source res_o
);
  localparam int W    = COORD_WIDTH;
  localparam int DW   = 2 * W + 1;
  localparam int QB   = W + 1;
  localparam int CMPW = (DW > THR_W) ? DW : THR_W;

  typedef struct packed {
    logic         par;
    logic         neg_x;
    logic         neg_y;
    logic [W-1:0] sx;
    logic [W-1:0] sy;
  } side_t;

  logic [THR_W-1:0] thr_q;
  logic en;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.data;
    end
  end

  assign en         = !res_o.valid || res_o.ready;
  assign pt_i.ready = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Stage 1: differences.
  logic signed [W:0] a1_q, a2_q, b1_q, b2_q, c1_q, c2_q;
  logic [W-1:0] sx1_q, sy1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= {pt_i.a_end_x[W-1], pt_i.a_end_x} - {pt_i.a_start_x[W-1], pt_i.a_start_x};
      a2_q  <= {pt_i.a_end_y[W-1], pt_i.a_end_y} - {pt_i.a_start_y[W-1], pt_i.a_start_y};
      b1_q  <= {pt_i.b_start_x[W-1], pt_i.b_start_x} - {pt_i.b_end_x[W-1], pt_i.b_end_x};
      b2_q  <= {pt_i.b_start_y[W-1], pt_i.b_start_y} - {pt_i.b_end_y[W-1], pt_i.b_end_y};
      c1_q  <= {pt_i.b_start_x[W-1], pt_i.b_start_x} - {pt_i.a_start_x[W-1], pt_i.a_start_x};
      c2_q  <= {pt_i.b_start_y[W-1], pt_i.b_start_y} - {pt_i.a_start_y[W-1], pt_i.a_start_y};
      sx1_q <= pt_i.a_start_x;
      sy1_q <= pt_i.a_start_y;
    end
  end

  // Stage 2: cross products.
  logic signed [2*W+1:0] pab_q, pba_q, pcb_q, pcc_q;
  logic signed [W:0] a1_2q, a2_2q;
  logic [W-1:0] sx2_q, sy2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pab_q <= a1_q * b2_q;
      pba_q <= a2_q * b1_q;
      pcb_q <= c1_q * b2_q;
      pcc_q <= c2_q * b1_q;
      a1_2q <= a1_q;
      a2_2q <= a2_q;
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
    end
  end

  // Stage 3: determinants, magnitudes and signs.
  logic [2*W+2:0] det_c, dt_c;
  logic [2*W+2:0] det_n, dt_n;
  logic [W:0] dx_n, dy_n;
  always_comb begin
    det_c = {pab_q[2*W+1], pab_q} - {pba_q[2*W+1], pba_q};
    dt_c  = {pcb_q[2*W+1], pcb_q} - {pcc_q[2*W+1], pcc_q};
    det_n = -det_c;
    dt_n  = -dt_c;
    dx_n  = -a1_2q;
    dy_n  = -a2_2q;
  end

  logic [DW-1:0] det_m_q, dt_m_q;
  logic [W-1:0]  dx_m_q, dy_m_q;
  logic          nx3_q, ny3_q;
  logic [W-1:0]  sx3_q, sy3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      det_m_q <= det_c[2*W+2] ? det_n[DW-1:0] : det_c[DW-1:0];
      dt_m_q  <= dt_c[2*W+2] ? dt_n[DW-1:0] : dt_c[DW-1:0];
      dx_m_q  <= a1_2q[W] ? dx_n[W-1:0] : a1_2q[W-1:0];
      dy_m_q  <= a2_2q[W] ? dy_n[W-1:0] : a2_2q[W-1:0];
      nx3_q   <= det_c[2*W+2] ^ dt_c[2*W+2] ^ a1_2q[W];
      ny3_q   <= det_c[2*W+2] ^ dt_c[2*W+2] ^ a2_2q[W];
      sx3_q   <= sx2_q;
      sy3_q   <= sy2_q;
    end
  end

  // Stage 4: partial products of the numerators and the parallel test.
  logic [2*W-1:0] lx_q, ly_q;
  logic [2*W:0]   hx_q, hy_q;
  logic [DW-1:0]  det4_q;
  logic           par4_q, nx4_q, ny4_q;
  logic [W-1:0]   sx4_q, sy4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      lx_q   <= dt_m_q[W-1:0] * dx_m_q;
      ly_q   <= dt_m_q[W-1:0] * dy_m_q;
      hx_q   <= dt_m_q[DW-1:W] * dx_m_q;
      hy_q   <= dt_m_q[DW-1:W] * dy_m_q;
      det4_q <= det_m_q;
      par4_q <= (det_m_q == '0) || (CMPW'(det_m_q) < CMPW'(thr_q));
      nx4_q  <= nx3_q;
      ny4_q  <= ny3_q;
      sx4_q  <= sx3_q;
      sy4_q  <= sy3_q;
    end
  end

  // Stage 5: full numerators.
  logic [3*W:0] nx_q, ny_q;
  logic [DW-1:0] det5_q;
  side_t side5;
  logic par5_q, nx5_q, ny5_q;
  logic [W-1:0] sx5_q, sy5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= {hx_q, {W{1'b0}}} + {{(W+1){1'b0}}, lx_q};
      ny_q   <= {hy_q, {W{1'b0}}} + {{(W+1){1'b0}}, ly_q};
      det5_q <= det4_q;
      par5_q <= par4_q;
      nx5_q  <= nx4_q;
      ny5_q  <= ny4_q;
      sx5_q  <= sx4_q;
      sy5_q  <= sy4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= pt_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_comb begin
    side5.par   = par5_q;
    side5.neg_x = nx5_q;
    side5.neg_y = ny5_q;
    side5.sx    = sx5_q;
    side5.sy    = sy5_q;
  end

  logic [W:0] qx, qy;
  logic       ox, oy;

  lli_div #(.W(W)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nx_q),
    .den_i (det5_q),
    .quo_o (qx),
    .ovf_o (ox)
  );

  lli_div #(.W(W)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ny_q),
    .den_i (det5_q),
    .quo_o (qy),
    .ovf_o (oy)
  );

  logic [QB:0] sv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[QB-1:0], v5_q};
    end
  end

  side_t side_q [QB+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side5;
      for (int i = 1; i <= QB; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Output stage: sign, offset and clamp.
  localparam logic [W+2:0] TOP = {4'b0000, {(W-1){1'b1}}};
  localparam logic [W+2:0] BOT = {4'b1111, {(W-1){1'b0}}};

  side_t sf;
  logic [W+2:0] qxs, qys, rx, ry;
  logic [W-1:0] fx, fy;
  logic         satx, saty;
  always_comb begin
    sf  = side_q[QB];
    qxs = sf.neg_x ? -{2'b00, qx} : {2'b00, qx};
    qys = sf.neg_y ? -{2'b00, qy} : {2'b00, qy};
    rx  = {{3{sf.sx[W-1]}}, sf.sx} + qxs;
    ry  = {{3{sf.sy[W-1]}}, sf.sy} + qys;
    satx = 1'b1;
    saty = 1'b1;
    if (ox) begin
      fx = sf.neg_x ? BOT[W-1:0] : TOP[W-1:0];
    end else if ($signed(rx) > $signed(TOP)) begin
      fx = TOP[W-1:0];
    end else if ($signed(rx) < $signed(BOT)) begin
      fx = BOT[W-1:0];
    end else begin
      fx   = rx[W-1:0];
      satx = 1'b0;
    end
    if (oy) begin
      fy = sf.neg_y ? BOT[W-1:0] : TOP[W-1:0];
    end else if ($signed(ry) > $signed(TOP)) begin
      fy = TOP[W-1:0];
    end else if ($signed(ry) < $signed(BOT)) begin
      fy = BOT[W-1:0];
    end else begin
      fy   = ry[W-1:0];
      saty = 1'b0;
    end
  end

  logic         ov_q;
  status_e      st_q;
  logic [W-1:0] ox_q, oy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= sv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sf.par) begin
        st_q <= ST_PARALLEL;
        ox_q <= '0;
        oy_q <= '0;
      end else begin
        st_q <= (satx || saty) ? ST_SAT : ST_OK;
        ox_q <= fx;
        oy_q <= fy;
      end
    end
  end

  assign res_o.valid   = ov_q;
  assign res_o.status  = st_q;
  assign res_o.cross_x = ox_q;
  assign res_o.cross_y = oy_q;
endmodule
`default_nettype wire

@@ sv/lli_checker.sv @@
// Port-level checks for the line-line intersection block, bound to the top.
// Depends on lli_pkg and line_line_intersection_top.
`default_nettype none
module lli_checker
  import lli_pkg::*;
#(
  parameter int W = 24
) (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         valid_i,
  input wire logic         ready_i,
  input wire logic [1:0]   status_i,
  input wire logic [W-1:0] cross_x_i,
  input wire logic [W-1:0] cross_y_i
);
  localparam logic [W-1:0] TOP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] BOT = {1'b1, {(W-1){1'b0}}};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result item dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable(status_i) && $stable(cross_x_i) && $stable(cross_y_i))
    else $error("result item changed while stalled");

  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i == ST_PARALLEL |-> cross_x_i == '0 && cross_y_i == '0)
    else $error("parallel result carries a nonzero point");

  a_sat_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i == ST_SAT |->
      cross_x_i == TOP || cross_x_i == BOT || cross_y_i == TOP || cross_y_i == BOT)
    else $error("saturated result has no clamped coordinate");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> status_i != 2'd3)
    else $error("undefined status code");
endmodule

bind line_line_intersection_top lli_checker #(.W(COORD_WIDTH)) u_lli_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_i   (res_o.valid),
  .ready_i   (res_o.ready),
  .status_i  (res_o.status),
  .cross_x_i (res_o.cross_x),
  .cross_y_i (res_o.cross_y)
);
`default_nettype wire

@@ tb/sv/line_line_intersection_top_tb.sv @@
// Self-checking testbench for line_line_intersection_top: directed line pairs, then
// random ones under several determinant thresholds, checked against listed results or a local predictor.
// Depends on lli_pkg, lli_if and the block's RTL.
module line_line_intersection_top_tb;
  import lli_pkg::*;

  localparam int CW = 24;
  localparam int LATENCY = CW + 8;
  localparam logic signed [CW-1:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [CW-1:0] CMIN = 24'sh800000;
  localparam int ONE = 4096;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic signed [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  } line_pair_t;

  typedef struct packed {
    status_e              status;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } crossing_t;

  typedef struct packed {
    line_pair_t pair;
    logic       typed;
    crossing_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lli_cfg_if      cfg ();
  lli_in_if #(CW)  pt ();
  lli_out_if #(CW) res ();

  line_line_intersection_top #(.COORD_WIDTH(CW)) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg),
    .pt_i  (pt),
    .res_o (res)
  );

  logic [THR_W-1:0] threshold = THR_RESET;
  crossing_t        pending_crossings[$];
  int               fails = 0;
  int               results_seen = 0;
  int               items_sent = 0;
  int               stall_left = 0;
  bit               stall_done = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 400000);
    $display("line_line_intersection_top verification failed");
    $finish;
  end

  function automatic logic [127:0] mag128(logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [CW-1:0] solve_axis(logic signed [127:0] start,
      logic signed [127:0] dt, logic signed [127:0] dir, logic signed [127:0] det,
      inout logic sat);
    logic neg;
    logic [127:0] quo;
    logic signed [127:0] r;
    neg = (dt < 0) ^ (dir < 0) ^ (det < 0);
    quo = (mag128(dt) * mag128(dir)) / mag128(det);
    if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
    r = neg ? start - $signed(quo) : start + $signed(quo);
    if (r > CMAX) begin
      r = CMAX;
      sat = 1'b1;
    end
    if (r < CMIN) begin
      r = CMIN;
      sat = 1'b1;
    end
    return r[CW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(line_pair_t p, logic [THR_W-1:0] thr);
    logic signed [127:0] a1, a2, b1, b2, c1, c2, det, dt;
    logic sat;
    crossing_t c;
    a1 = p.ax2 - p.ax1;
    a2 = p.ay2 - p.ay1;
    b1 = p.bx1 - p.bx2;
    b2 = p.by1 - p.by2;
    c1 = p.bx1 - p.ax1;
    c2 = p.by1 - p.ay1;
    det = a1 * b2 - a2 * b1;
    dt = c1 * b2 - c2 * b1;
    sat = 1'b0;
    if (det == 0 || mag128(det) < {77'd0, thr}) begin
      c.status = ST_PARALLEL;
      c.x = '0;
      c.y = '0;
      return c;
    end
    c.x = solve_axis(p.ax1, dt, a1, det, sat);
    c.y = solve_axis(p.ay1, dt, a2, det, sat);
    c.status = sat ? ST_SAT : ST_OK;
    return c;
  endfunction

  function automatic logic signed [CW-1:0] rnd_s(int lim);
    return CW'($signed($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic logic signed [CW-1:0] rnd_edge();
    case ($urandom_range(0, 4))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3: return CW'(-1);
      default: return CW'(1);
    endcase
  endfunction

  function automatic line_pair_t random_pair();
    line_pair_t p;
    logic signed [CW-1:0] dx, dy;
    int k;
    p = '{CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
          CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom)};
    case ($urandom_range(0, 9))
      3, 4: p = '{rnd_s(1 << 14), rnd_s(1 << 14), rnd_s(1 << 14), rnd_s(1 << 14),
                  rnd_s(1 << 14), rnd_s(1 << 14), rnd_s(1 << 14), rnd_s(1 << 14)};
      5, 6: begin
        dx = rnd_s(1 << 16);
        dy = rnd_s(1 << 16);
        p.ax1 = rnd_s(1 << 20);
        p.ay1 = rnd_s(1 << 20);
        p.ax2 = p.ax1 + dx;
        p.ay2 = p.ay1 + dy;
        p.bx1 = p.ax1 + rnd_s(1 << 18);
        p.by1 = p.ay1 + rnd_s(1 << 18);
        p.bx2 = p.bx1 + dx + rnd_s(3);
        p.by2 = p.by1 + dy + rnd_s(3);
      end
      7: begin
        p.ax2 = p.ax1;
        p.ay2 = p.ay1;
        if ($urandom_range(0, 1)) begin
          p.bx2 = p.bx1;
          p.by2 = p.by1;
        end
      end
      8: p = '{rnd_edge(), rnd_edge(), rnd_edge(), rnd_edge(),
               rnd_edge(), rnd_edge(), rnd_edge(), rnd_edge()};
      9: begin
        dx = rnd_s(1 << 10);
        dy = rnd_s(1 << 10);
        k = $urandom_range(1, 8);
        p.ax1 = rnd_s(1 << 20);
        p.ay1 = rnd_s(1 << 20);
        p.ax2 = p.ax1 + dx;
        p.ay2 = p.ay1 + dy;
        p.bx1 = rnd_s(1 << 20);
        p.by1 = rnd_s(1 << 20);
        p.bx2 = p.bx1 - CW'(k * dx);
        p.by2 = p.by1 - CW'(k * dy);
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic bit sender_calm();
    return items_sent >= 900 && items_sent < 1200;
  endfunction

  task automatic send_pair(line_pair_t p, logic typed, crossing_t want);
    while (!sender_calm() && $urandom_range(0, 99) < 26) begin
      pt.valid <= 1'b0;
      @(negedge clk);
    end
    pt.valid <= 1'b1;
    {pt.a_start_x, pt.a_start_y, pt.a_end_x, pt.a_end_y,
     pt.b_start_x, pt.b_start_y, pt.b_end_x, pt.b_end_y} <= p;
    do @(posedge clk); while (!pt.ready);
    pending_crossings.push_back(typed ? want : predict_crossing(p, threshold));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    pt.valid <= 1'b0;
    while (pending_crossings.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    threshold = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && results_seen >= 300) begin
      res.ready <= 1'b0;
      stall_left <= 300;
      stall_done <= 1'b1;
    end else if (results_seen >= 600 && results_seen < 900) begin
      res.ready <= 1'b1;
    end else begin
      res.ready <= $urandom_range(0, 99) >= 26;
    end
  end

  always @(posedge clk) begin
    crossing_t want;
    if (rst_n && res.valid && res.ready) begin
      results_seen++;
      if (pending_crossings.size() == 0) begin
        $error("result with no expected item: status %0d x %0d y %0d",
               res.status, $signed(res.cross_x), $signed(res.cross_y));
        fails++;
      end else begin
        want = pending_crossings.pop_front();
        if (res.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res.status);
          fails++;
        end
        if (res.cross_x !== want.x) begin
          $error("cross_x: expected %0d, actual %0d", want.x, $signed(res.cross_x));
          fails++;
        end
        if (res.cross_y !== want.y) begin
          $error("cross_y: expected %0d, actual %0d", want.y, $signed(res.cross_y));
          fails++;
        end
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    logic [THR_W-1:0] thr_plan[NUM_PHASES];
    int waited;
    pt.valid = 1'b0;
    {pt.a_start_x, pt.a_start_y, pt.a_end_x, pt.a_end_y,
     pt.b_start_x, pt.b_start_y, pt.b_end_x, pt.b_end_y} = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;

    rows = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{ST_PARALLEL, 24'sd0, 24'sd0}},
      '{'{-ONE, 0, ONE, 0, 0, -ONE, 0, ONE}, 1'b1, '{ST_OK, 24'sd0, 24'sd0}},
      '{'{0, 0, ONE, 0, 0, ONE, ONE, ONE}, 1'b1, '{ST_PARALLEL, 24'sd0, 24'sd0}},
      '{'{0, 0, ONE, ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE}, 1'b1,
        '{ST_PARALLEL, 24'sd0, 24'sd0}},
      '{'{ONE, ONE, ONE, ONE, 0, -ONE, 0, ONE}, 1'b1, '{ST_PARALLEL, 24'sd0, 24'sd0}},
      '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1,
        '{ST_PARALLEL, 24'sd0, 24'sd0}},
      '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1,
        '{ST_PARALLEL, 24'sd0, 24'sd0}},
      '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, '0},
      '{'{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN}, 1'b0, '0},
      '{'{0, 0, 4096000, 1, 0, ONE, 4096000, ONE + 2}, 1'b0, '0},
      '{'{0, 0, 4096000, 1, 0, -ONE, 4096000, -ONE + 2}, 1'b0, '0},
      '{'{CMIN, 0, CMAX, 1, CMIN, 1, CMAX, 1}, 1'b0, '0},
      '{'{0, CMIN, 1, CMAX, 1, CMIN, 2, CMAX}, 1'b0, '0},
      '{'{CMAX, 0, CMAX - 1, ONE, CMIN, 0, CMIN + 1, ONE}, 1'b0, '0},
      '{'{3*ONE, ONE, -ONE, 5*ONE, 7, -9, 11, 13}, 1'b0, '0},
      '{'{-1, -1, 1, 1, -1, 1, 1, -1}, 1'b0, '0}
    };
    thr_plan = '{THR_RESET, '0, {THR_W{1'b1}}, THR_W'(1) << 24,
                 THR_W'({$urandom, $urandom}) >> $urandom_range(0, THR_W - 1), THR_W'(1)};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].want);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        drain_and_settle();
        write_threshold(thr_plan[ph]);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_pair(random_pair(), 1'b0, '0);
    end

    pt.valid <= 1'b0;
    waited = 0;
    while (pending_crossings.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY + 8) @(negedge clk);
    if (pending_crossings.size() != 0) begin
      $error("%0d expected results never arrived", pending_crossings.size());
      fails++;
    end
    if (fails == 0) begin
      $display("line_line_intersection_top verification clean");
    end else begin
      $display("line_line_intersection_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/lli_pkg.sv
sv/lli_if.sv
sv/lli_div.sv
sv/line_line_intersection_top.sv
sv/lli_checker.sv
tb/sv/line_line_intersection_top_tb.sv
